>>> rtl/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types and constants of the cycle counter calibrator.
// ----------------------------------------------------------------------------
package ccc_pkg;

	// field and datapath widths
	localparam int unsigned STAMP_W      = 64;
	localparam int unsigned SAMPLE_W     = 16;
	localparam int unsigned OP_W         = 2;
	localparam int unsigned STATUS_W     = 2;
	localparam int unsigned TICKS_W      = 16;
	localparam int unsigned REFHZ_W      = 27;
	localparam int unsigned CFG_DATA_W   = 27;
	localparam int unsigned CFG_INDEX_W  = 1;
	localparam int unsigned ELAPSED_W    = 32;
	localparam int unsigned DIV_W        = 64;
	localparam int unsigned MUL_A_W      = 32;
	localparam int unsigned MUL_C_W      = 20;
	localparam int unsigned MUL_W        = MUL_A_W + MUL_C_W;
	localparam int unsigned IN_TDATA_W   = 80;
	localparam int unsigned OUT_TDATA_W  = 136;

	// default width of the reference down-counter
	localparam int unsigned COUNTER_BITS_DEF = 16;

	// microseconds per second
	localparam logic [MUL_C_W-1:0] US_PER_SEC = 20'd1000000;

	// register reset values
	localparam logic [TICKS_W-1:0] CALIB_TICKS_RST = 16'd50;
	localparam logic [REFHZ_W-1:0] REF_CLOCK_HZ_RST = 27'd1193182;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_CALIB_TICKS  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_REF_CLOCK_HZ = 1'b1;

	// opcodes
	localparam logic [OP_W-1:0] OP_START   = 2'd0;
	localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd1;
	localparam logic [OP_W-1:0] OP_CONVERT = 2'd2;

	// result kinds
	localparam logic KIND_CALIB = 1'b0;
	localparam logic KIND_CONV  = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNCAL = 2'd2;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_CHECK,
		S_MUL_PER,
		S_PMUL_LO,
		S_PMUL_HI,
		S_PMUL_SUM,
		S_MUL_LO,
		S_MUL_HI,
		S_MUL_SUM,
		S_DIV_GO,
		S_DIV_WAIT,
		S_OUT
	} state_t;

	// what the shared divider is working on
	typedef enum logic [1:0] {
		PH_PERIOD,
		PH_FREQ,
		PH_MHZ,
		PH_CONV
	} phase_t;

	// divider request and answer
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> rtl/ccc_div.sv
// ----------------------------------------------------------------------------
// ccc_div
// Restoring radix-2 divider, one quotient bit per cycle, registered result.
// ----------------------------------------------------------------------------
module ccc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ccc_pkg::div_req_t  req,
	output ccc_pkg::div_rsp_t  rsp
);
	import ccc_pkg::*;

	localparam int unsigned CNT_W = $clog2(DIV_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W:0]   rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] den_q;

	logic [DIV_W:0]   shifted;
	logic             fits;

	// trial subtract of the shifted partial remainder
	always_comb begin
		shifted = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
		fits    = (shifted >= {1'b0, den_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_LAST);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (shifted - {1'b0, den_q}) : shifted;
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> rtl/cycle_counter_calibrator.sv
// ----------------------------------------------------------------------------
// cycle_counter_calibrator
// Calibrates a free-running cycle counter against a down-counting timer.
// ----------------------------------------------------------------------------
// Input requests arrive on the s_axis channel: tuser carries the opcode
// (start, counter sample, convert), tdata the counter sample and cycle stamp.
// Results leave on m_axis: tuser is the kind (calibration done or
// conversion answer), tdata the frequency, microseconds and status.
// Registers calib_ticks and ref_clock_hz are written on the cfg port.
// One request is taken at a time; s_axis_tready is high only while the
// sequencer is idle. A start or a sample that does not close the window
// frees the input from the decode or check state. A closing sample runs
// three divisions on the shared divider and seven 32x20 multiply and add
// steps. A convert request runs one division; an uncalibrated or sub-MHz
// read answers without a division. The input is free again in the cycle
// after the result is loaded. The result sits in an output register; a
// stalled receiver holds it there, the next request is still accepted and
// its result waits for the slot. Reset clears the registers to their
// defaults and the block uncalibrated.
// ----------------------------------------------------------------------------
module cycle_counter_calibrator #(
	parameter int unsigned COUNTER_BITS = ccc_pkg::COUNTER_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write port
	input  logic                                cfg_we,
	input  logic [ccc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ccc_pkg::CFG_DATA_W-1:0]      cfg_data,
	// request channel
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// counter_sample [15:0], cycle_stamp [79:16]
	input  logic [ccc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// opcode [1:0]
	input  logic [ccc_pkg::OP_W-1:0]            s_axis_tuser,
	// result channel
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// cycle_freq_hz [63:0], microseconds [127:64], status [129:128], zero fill
	output logic [ccc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// kind [0]
	output logic                                m_axis_tuser
);
	import ccc_pkg::*;

	localparam int unsigned EW = (COUNTER_BITS > SAMPLE_W) ? COUNTER_BITS : SAMPLE_W;
	localparam int unsigned MASK_BITS = (COUNTER_BITS < SAMPLE_W) ? COUNTER_BITS : SAMPLE_W;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
		SAMPLE_W'((33'd1 << MASK_BITS) - 33'd1);

	state_t state_q, state_d;
	phase_t phase_q, phase_d;

	// config registers
	logic [TICKS_W-1:0] calib_ticks_q;
	logic [REFHZ_W-1:0] ref_hz_q;

	// latched request
	logic [OP_W-1:0]     item_op_q;
	logic [SAMPLE_W-1:0] item_sample_q;
	logic [STAMP_W-1:0]  item_stamp_q;

	// calibration state
	logic [STAMP_W-1:0]   start_stamp_q;
	logic [SAMPLE_W-1:0]  last_sample_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic                 measuring_q;
	logic [STAMP_W-1:0]   freq_store_q;
	logic [STAMP_W-1:0]   mhz_q;

	// working registers
	logic [STAMP_W-1:0] cycles_q;
	logic [MUL_W-1:0]   mul_q;
	logic [STAMP_W-1:0] acc_q;
	logic [DIV_W-1:0]   period_q;
	// period times 10^6, divisor for the frequency in MHz
	logic [DIV_W-1:0]   period_scaled_q;

	// pending result
	logic                res_kind_q;
	logic [STAMP_W-1:0]  res_freq_q;
	logic [STAMP_W-1:0]  res_us_q;
	logic [STATUS_W-1:0] res_status_q;

	// output register
	logic                out_valid_q;
	logic                out_kind_q;
	logic [STAMP_W-1:0]  out_freq_q;
	logic [STAMP_W-1:0]  out_us_q;
	logic [STATUS_W-1:0] out_status_q;

	logic                 accept;
	logic                 out_load;
	logic [EW-1:0]        diff_w;
	logic [COUNTER_BITS-1:0] delta;
	logic [ELAPSED_W:0]   sum;
	logic [ELAPSED_W-1:0] elapsed_next;
	logic                 window_done;
	logic [MUL_A_W-1:0]   mul_a;
	div_req_t             div_req;
	div_rsp_t             div_rsp;
	logic [DIV_W-1:0]     quo;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign quo    = div_rsp.quotient;

	// elapsed down-count, modulo the counter width, saturating total
	always_comb begin
		diff_w       = EW'(last_sample_q) - EW'(item_sample_q);
		delta        = diff_w[COUNTER_BITS-1:0];
		sum          = {1'b0, elapsed_q} + (ELAPSED_W + 1)'(delta);
		elapsed_next = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
		window_done  = (elapsed_q >= ELAPSED_W'(calib_ticks_q));
	end

	// shared 32x20 multiplier operand
	always_comb begin
		case (state_q)
			S_MUL_PER: mul_a = MUL_A_W'(calib_ticks_q);
			S_PMUL_LO: mul_a = period_q[MUL_A_W-1:0];
			S_PMUL_HI: mul_a = period_q[DIV_W-1:MUL_A_W];
			S_MUL_LO:  mul_a = cycles_q[MUL_A_W-1:0];
			default:   mul_a = cycles_q[STAMP_W-1:MUL_A_W];
		endcase
	end

	// divider operands
	always_comb begin
		div_req.start = (state_q == S_DIV_GO);
		case (phase_q)
			PH_PERIOD: begin
				div_req.dividend = DIV_W'(mul_q);
				div_req.divisor  = DIV_W'(ref_hz_q);
			end
			PH_FREQ: begin
				div_req.dividend = acc_q;
				div_req.divisor  = period_q;
			end
			// frequency in MHz straight from the wrapped product
			PH_MHZ: begin
				div_req.dividend = acc_q;
				div_req.divisor  = period_scaled_q;
			end
			default: begin
				div_req.dividend = item_stamp_q;
				div_req.divisor  = mhz_q;
			end
		endcase
	end

	ccc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_PERIOD;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d       = state_q;
		phase_d       = phase_q;
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (item_op_q)
					OP_SAMPLE: state_d = measuring_q ? S_CHECK : S_IDLE;
					OP_CONVERT: begin
						if (freq_store_q == '0 || mhz_q == '0) begin
							state_d = S_OUT;
						end else begin
							phase_d = PH_CONV;
							state_d = S_DIV_GO;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_CHECK: begin
				if (!window_done) begin
					state_d = S_IDLE;
				end else if (ref_hz_q == '0) begin
					state_d = S_OUT;
				end else begin
					state_d = S_MUL_PER;
				end
			end
			S_MUL_PER: begin
				phase_d = PH_PERIOD;
				state_d = S_DIV_GO;
			end
			S_PMUL_LO:  state_d = S_PMUL_HI;
			S_PMUL_HI:  state_d = S_PMUL_SUM;
			S_PMUL_SUM: state_d = S_MUL_LO;
			S_MUL_LO:  state_d = S_MUL_HI;
			S_MUL_HI:  state_d = S_MUL_SUM;
			S_MUL_SUM: begin
				phase_d = PH_FREQ;
				state_d = S_DIV_GO;
			end
			S_DIV_GO:  state_d = S_DIV_WAIT;
			S_DIV_WAIT: begin
				if (div_rsp.done) begin
					case (phase_q)
						PH_PERIOD: state_d = (quo == '0) ? S_OUT : S_PMUL_LO;
						PH_FREQ: begin
							if (quo == '0) begin
								state_d = S_OUT;
							end else begin
								phase_d = PH_MHZ;
								state_d = S_DIV_GO;
							end
						end
						default: state_d = S_OUT;
					endcase
				end
			end
			S_OUT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_ticks_q <= CALIB_TICKS_RST;
			ref_hz_q      <= REF_CLOCK_HZ_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CALIB_TICKS:  calib_ticks_q <= cfg_data[TICKS_W-1:0];
				REG_REF_CLOCK_HZ: ref_hz_q      <= cfg_data[REFHZ_W-1:0];
				default: ;
			endcase
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if (accept) begin
			item_op_q     <= s_axis_tuser;
			item_sample_q <= s_axis_tdata[SAMPLE_W-1:0] & SAMPLE_MASK;
			item_stamp_q  <= s_axis_tdata[SAMPLE_W +: STAMP_W];
		end
	end

	// calibration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_stamp_q <= '0;
			last_sample_q <= '0;
			elapsed_q     <= '0;
			measuring_q   <= 1'b0;
			freq_store_q  <= '0;
			mhz_q         <= '0;
		end else begin
			case (state_q)
				S_DECODE: begin
					if (item_op_q == OP_START) begin
						start_stamp_q <= item_stamp_q;
						last_sample_q <= item_sample_q;
						elapsed_q     <= '0;
						measuring_q   <= 1'b1;
					end else if (item_op_q == OP_SAMPLE && measuring_q) begin
						elapsed_q     <= elapsed_next;
						last_sample_q <= item_sample_q;
					end
				end
				S_CHECK: begin
					if (window_done) begin
						measuring_q <= 1'b0;
						if (ref_hz_q == '0) begin
							freq_store_q <= '0;
						end
					end
				end
				S_DIV_WAIT: begin
					if (div_rsp.done) begin
						case (phase_q)
							PH_PERIOD: if (quo == '0) freq_store_q <= '0;
							PH_FREQ:   freq_store_q <= quo;
							PH_MHZ:    mhz_q <= quo;
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	// multiply steps and working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_CHECK:   cycles_q <= item_stamp_q - start_stamp_q;
			S_MUL_PER: mul_q <= MUL_W'(mul_a) * MUL_W'(US_PER_SEC);
			S_PMUL_LO: mul_q <= MUL_W'(mul_a) * MUL_W'(US_PER_SEC);
			S_PMUL_HI: begin
				period_scaled_q <= DIV_W'(mul_q);
				mul_q           <= MUL_W'(mul_a) * MUL_W'(US_PER_SEC);
			end
			S_PMUL_SUM: period_scaled_q <= period_scaled_q +
				{mul_q[MUL_A_W-1:0], {MUL_A_W{1'b0}}};
			S_MUL_LO:  mul_q <= MUL_W'(mul_a) * MUL_W'(US_PER_SEC);
			S_MUL_HI: begin
				acc_q <= STAMP_W'(mul_q);
				mul_q <= MUL_W'(mul_a) * MUL_W'(US_PER_SEC);
			end
			S_MUL_SUM: acc_q <= acc_q + {mul_q[MUL_A_W-1:0], {MUL_A_W{1'b0}}};
			S_DIV_WAIT: begin
				if (div_rsp.done && phase_q == PH_PERIOD) begin
					period_q <= quo;
				end
			end
			default: ;
		endcase
	end

	// pending result fields
	always_ff @(posedge clk) begin
		case (state_q)
			S_DECODE: begin
				res_kind_q <= KIND_CONV;
				res_us_q   <= '0;
				if (freq_store_q == '0) begin
					res_freq_q   <= '0;
					res_status_q <= ST_UNCAL;
				end else begin
					res_freq_q   <= freq_store_q;
					res_status_q <= ST_ZERO;
				end
			end
			S_CHECK: begin
				res_kind_q   <= KIND_CALIB;
				res_freq_q   <= '0;
				res_us_q     <= '0;
				res_status_q <= ST_ZERO;
			end
			S_DIV_WAIT: begin
				if (div_rsp.done) begin
					case (phase_q)
						PH_PERIOD: begin
							res_kind_q   <= KIND_CALIB;
							res_freq_q   <= '0;
							res_us_q     <= '0;
							res_status_q <= ST_ZERO;
						end
						PH_FREQ: begin
							res_kind_q   <= KIND_CALIB;
							res_freq_q   <= quo;
							res_us_q     <= '0;
							res_status_q <= (quo == '0) ? ST_ZERO : ST_OK;
						end
						PH_MHZ: res_status_q <= ST_OK;
						default: begin
							res_kind_q   <= KIND_CONV;
							res_freq_q   <= freq_store_q;
							res_us_q     <= quo;
							res_status_q <= ST_OK;
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q   <= res_kind_q;
			out_freq_q   <= res_freq_q;
			out_us_q     <= res_us_q;
			out_status_q <= res_status_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = {
		(OUT_TDATA_W - 2 * STAMP_W - STATUS_W)'(0),
		out_status_q, out_us_q, out_freq_q
	};

endmodule

>>> rtl/ccc_checker.sv
// ----------------------------------------------------------------------------
// ccc_checker
// Port-level checks of the cycle counter calibrator, bound to the top level.
// ----------------------------------------------------------------------------
module ccc_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [ccc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                            m_axis_tuser
);
	import ccc_pkg::*;

	logic [STAMP_W-1:0]  freq;
	logic [STAMP_W-1:0]  usec;
	logic [STATUS_W-1:0] status;

	assign freq   = m_axis_tdata[STAMP_W-1:0];
	assign usec   = m_axis_tdata[2*STAMP_W-1:STAMP_W];
	assign status = m_axis_tdata[2*STAMP_W +: STATUS_W];

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// one request at a time: busy right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while sequencer busy");

	// calibration result: status ok exactly when the frequency is nonzero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_CALIB |->
			usec == '0 && (status == ST_OK || status == ST_ZERO) &&
			((status == ST_OK) == (freq != '0)))
		else $error("inconsistent calibration result");

	// uncalibrated read gives all zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_CONV && status == ST_UNCAL |->
			freq == '0 && usec == '0)
		else $error("uncalibrated read with nonzero fields");

	// slow clock read: stored frequency but no time
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_CONV && status == ST_ZERO |->
			freq != '0 && usec == '0)
		else $error("zero divisor read inconsistent");

endmodule

bind cycle_counter_calibrator ccc_checker u_ccc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
